@@ src/isbnv_pkg.sv @@
package isbnv_pkg;

	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPPER_X = 8'h58;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;

	localparam logic [3:0] COUNT_MAX    = 4'd15;
	localparam logic [3:0] COUNT_SBN    = 4'd8;
	localparam logic [3:0] COUNT_ISBN10 = 4'd9;
	localparam logic [3:0] COUNT_ISBN13 = 4'd12;
	localparam logic [3:0] RESIDUE_TEN  = 4'd10;

	typedef struct packed {
		logic [3:0] digit_count;
		logic [3:0] sum_sbn;
		logic [3:0] sum_isbn10;
		logic [3:0] sum_isbn13;
		logic [7:0] pending_char;
		logic       have_pending;
		logic       bad_char_seen;
	} isbnv_state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// x below 128: quotient by reciprocal 187/2048, then one correction
	function automatic logic [3:0] mod11(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = 15'(x) * 15'd187;
		q = p[14:11];
		r = x - 7'(q * 4'd11);
		if (r >= 7'd11) begin
			r = r - 7'd11;
		end
		return r[3:0];
	endfunction

	// x below 64: quotient by reciprocal 205/2048, then one correction
	function automatic logic [3:0] mod10(input logic [5:0] x);
		logic [13:0] p;
		logic [2:0]  q;
		logic [5:0]  r;
		p = 14'(x) * 14'd205;
		q = p[13:11];
		r = x - 6'(q * 4'd10);
		if (r >= 6'd10) begin
			r = r - 6'd10;
		end
		return r[3:0];
	endfunction

endpackage

@@ src/isbnv_fold.sv @@
module isbnv_fold (
	input  isbnv_pkg::isbnv_state_t cur,
	input  logic [7:0]              c,
	output isbnv_pkg::isbnv_state_t nxt
);

	logic [3:0] d;
	logic [4:0] w10_raw;
	logic [4:0] w11_raw;
	logic [3:0] w10;
	logic [3:0] w11;
	logic [7:0] acc10;
	logic [7:0] acc11;
	logic [5:0] acc13;

	assign d       = 4'(c - isbnv_pkg::CHAR_ZERO);
	assign w10_raw = {1'b0, cur.digit_count} + 5'd1;
	assign w11_raw = {1'b0, cur.digit_count} + 5'd2;
	assign w10     = (w10_raw >= 5'd11) ? 4'(w10_raw - 5'd11) : w10_raw[3:0];
	assign w11     = (w11_raw >= 5'd11) ? 4'(w11_raw - 5'd11) : w11_raw[3:0];
	assign acc10   = 8'(cur.sum_isbn10) + 8'(d) * 8'(w10);
	assign acc11   = 8'(cur.sum_sbn) + 8'(d) * 8'(w11);
	assign acc13   = 6'(cur.sum_isbn13) + (cur.digit_count[0] ? 6'(d) * 6'd3 : 6'(d));

	always_comb begin
		nxt = cur;
		if (!isbnv_pkg::is_digit(c)) begin
			nxt.bad_char_seen = 1'b1;
		end else if (cur.digit_count != isbnv_pkg::COUNT_MAX) begin
			nxt.sum_sbn     = isbnv_pkg::mod11(acc11[6:0]);
			nxt.sum_isbn10  = isbnv_pkg::mod11(acc10[6:0]);
			nxt.sum_isbn13  = isbnv_pkg::mod10(acc13);
			nxt.digit_count = cur.digit_count + 4'd1;
		end
	end

endmodule

@@ src/isbnv_judge.sv @@
module isbnv_judge (
	input  isbnv_pkg::isbnv_state_t cur,
	output logic                    is_valid,
	output logic                    rewrite_to_x
);

	logic [7:0] m;
	logic       m_digit;
	logic [3:0] dv;
	logic [3:0] r11;
	logic [3:0] r13;
	logic       sym_mark;

	assign m        = cur.pending_char;
	assign m_digit  = isbnv_pkg::is_digit(m);
	assign dv       = 4'(m - isbnv_pkg::CHAR_ZERO);
	assign r11      = (cur.digit_count == isbnv_pkg::COUNT_SBN) ? cur.sum_sbn : cur.sum_isbn10;
	assign r13      = (cur.sum_isbn13 == 4'd0) ? 4'd0 : 4'd10 - cur.sum_isbn13;
	assign sym_mark = (m == isbnv_pkg::CHAR_LOWER_X) || (m == isbnv_pkg::CHAR_PLUS)
		|| (m == isbnv_pkg::CHAR_STAR);

	always_comb begin
		is_valid     = 1'b0;
		rewrite_to_x = 1'b0;
		if (cur.have_pending && !cur.bad_char_seen) begin
			if (cur.digit_count == isbnv_pkg::COUNT_SBN
				|| cur.digit_count == isbnv_pkg::COUNT_ISBN10) begin
				if (r11 == isbnv_pkg::RESIDUE_TEN) begin
					is_valid     = (m == isbnv_pkg::CHAR_UPPER_X) || sym_mark;
					rewrite_to_x = sym_mark;
				end else begin
					is_valid = m_digit && (dv == r11);
				end
			end else if (cur.digit_count == isbnv_pkg::COUNT_ISBN13) begin
				is_valid = m_digit && (dv == r13);
			end
		end
	end

endmodule

@@ src/isbn_check_digit_validator_core.sv @@
// ISBN check-digit validator. Feed the string one character word per cycle on
// char_code; hyphens are skipped and a zero word ends the string. Each zero word
// yields exactly one result word (is_valid, rewrite_to_x), presented on the output
// after it passes the input register and the result register; other characters
// yield nothing. Throughput is one word per cycle: the input register hands its
// word to the residue update and result register, and in_ready drops only while
// a terminator sits in the input register behind a result that has not yet been taken.
module isbn_check_digit_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_valid,
	output logic       rewrite_to_x
);

	logic                    v_s1;
	logic [7:0]              char_s1;
	logic                    adv_s1;
	logic                    term_s1;
	logic                    out_free;
	isbnv_pkg::isbnv_state_t state_q;
	isbnv_pkg::isbnv_state_t folded;
	isbnv_pkg::isbnv_state_t state_nxt;
	logic                    judge_valid;
	logic                    judge_rewrite;
	logic                    out_valid_q;
	logic                    is_valid_q;
	logic                    rewrite_q;

	assign term_s1  = (char_s1 == isbnv_pkg::CHAR_NUL);
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = v_s1 && (!term_s1 || out_free);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	isbnv_fold u_fold (
		.cur (state_q),
		.c   (state_q.pending_char),
		.nxt (folded)
	);

	isbnv_judge u_judge (
		.cur          (state_q),
		.is_valid     (judge_valid),
		.rewrite_to_x (judge_rewrite)
	);

	always_comb begin
		state_nxt = state_q;
		if (term_s1) begin
			state_nxt = '0;
		end else if (char_s1 != isbnv_pkg::CHAR_HYPHEN) begin
			if (state_q.have_pending) begin
				state_nxt = folded;
			end
			state_nxt.pending_char = char_s1;
			state_nxt.have_pending = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && term_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && term_s1) begin
			is_valid_q <= judge_valid;
			rewrite_q  <= judge_rewrite;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_valid     = is_valid_q;
	assign rewrite_to_x = rewrite_q;

	a_rewrite_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!rewrite_q || is_valid_q))
		else $error("rewrite flagged on an invalid result");

	a_clear_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && term_s1) |=> (state_q.digit_count == 4'd0 && !state_q.have_pending
			&& !state_q.bad_char_seen))
		else $error("state not cleared after terminator");

	a_count_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.digit_count != 4'd0) |-> state_q.have_pending)
		else $error("digits folded without a pending character");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(char_s1)))
		else $error("input register lost a stalled word");

	a_term_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && term_s1) |=> out_valid_q)
		else $error("terminator advanced without producing a result");

endmodule
